/* design/caf_pkg.sv */
package caf_pkg;

  // field widths
  localparam int unsigned ID_W   = 29;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TBIT_W = 4;
  localparam int unsigned MASK_W = 12;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned MODE_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIVE  = 2'd2;

  // protocol modes
  localparam logic [MODE_W-1:0] MODE_RANGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TABLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIAG  = 2'd2;

  // register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PROTOCOL_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_BASE_ID   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_BASE_ID   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_SEL_MASK  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RESPONSE_ID     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIVE_DURATION   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STALE_LIMIT     = 3'd6;

  // register reset values
  localparam logic [ID_W-1:0]   TABLE_BASE_RST    = 29'd864;
  localparam logic [MASK_W-1:0] FRAME_MASK_RST    = 12'hFFF;
  localparam logic [ID_W-1:0]   RESPONSE_ID_RST   = 29'd2024;
  localparam logic [MS_W-1:0]   LIVE_DURATION_RST = 16'd5000;
  localparam logic [MS_W-1:0]   STALE_LIMIT_RST   = 16'd3000;

  // filter constants
  localparam logic [TBIT_W-1:0] NO_TABLE_BIT = 4'd12;
  localparam logic [ID_W:0]     QUIET_SPAN   = 30'h200;
  localparam logic [ID_W:0]     RANGE_SPAN   = 30'd3;
  localparam logic [BYTE_W-1:0] DIAG_MARK    = 8'h41;
  localparam logic [LEN_W-1:0]  DIAG_MIN_LEN = 4'd4;
  localparam logic [MS_W-1:0]   AGE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] second_byte;
  } caf_in_t;

  typedef struct packed {
    logic              accepted;
    logic              quiet_reject;
    logic [TBIT_W-1:0] table_bit;
    logic              live_active;
    logic              data_valid;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  matched_count;
  } caf_out_t;

  typedef struct packed {
    logic [MODE_W-1:0] protocol_mode;
    logic [ID_W-1:0]   range_base_id;
    logic [ID_W-1:0]   table_base_id;
    logic [MASK_W-1:0] frame_select_mask;
    logic [ID_W-1:0]   response_id;
    logic [MS_W-1:0]   live_duration_ms;
    logic [MS_W-1:0]   stale_limit_ms;
  } caf_cfg_t;

  typedef struct packed {
    logic              acc;
    logic              quiet;
    logic [TBIT_W-1:0] tbit;
  } caf_match_t;

  // id offset to table bit, NO_TABLE_BIT when the offset is not listed
  function automatic logic [TBIT_W-1:0] offset_to_bit(input logic [ID_W-1:0] off);
    logic [TBIT_W-1:0] b;
    case (off)
      29'd0:    b = 4'd0;
      29'd1:    b = 4'd1;
      29'd2:    b = 4'd2;
      29'd8:    b = 4'd3;
      29'd9:    b = 4'd4;
      29'd16:   b = 4'd5;
      29'd18:   b = 4'd6;
      29'd19:   b = 4'd7;
      29'd20:   b = 4'd8;
      29'd21:   b = 4'd9;
      29'h80:   b = 4'd10;
      29'h82:   b = 4'd11;
      default:  b = NO_TABLE_BIT;
    endcase
    return b;
  endfunction

endpackage

/* design/caf_if.sv */
interface caf_in_if import caf_pkg::*; ();
  logic    valid;
  logic    ready;
  caf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface caf_out_if import caf_pkg::*; ();
  logic     valid;
  logic     ready;
  caf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/caf_regs.sv */
module caf_regs import caf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output caf_cfg_t    cfg
);

  caf_cfg_t             cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_mode     <= MODE_RANGE;
      cfg_r.range_base_id     <= '0;
      cfg_r.table_base_id     <= TABLE_BASE_RST;
      cfg_r.frame_select_mask <= FRAME_MASK_RST;
      cfg_r.response_id       <= RESPONSE_ID_RST;
      cfg_r.live_duration_ms  <= LIVE_DURATION_RST;
      cfg_r.stale_limit_ms    <= STALE_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PROTOCOL_MODE:  cfg_r.protocol_mode     <= pwdata[MODE_W-1:0];
        REG_RANGE_BASE_ID:  cfg_r.range_base_id     <= pwdata[ID_W-1:0];
        REG_TABLE_BASE_ID:  cfg_r.table_base_id     <= pwdata[ID_W-1:0];
        REG_FRAME_SEL_MASK: cfg_r.frame_select_mask <= pwdata[MASK_W-1:0];
        REG_RESPONSE_ID:    cfg_r.response_id       <= pwdata[ID_W-1:0];
        REG_LIVE_DURATION:  cfg_r.live_duration_ms  <= pwdata[MS_W-1:0];
        REG_STALE_LIMIT:    cfg_r.stale_limit_ms    <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PROTOCOL_MODE:  prdata = 32'(cfg_r.protocol_mode);
      REG_RANGE_BASE_ID:  prdata = 32'(cfg_r.range_base_id);
      REG_TABLE_BASE_ID:  prdata = 32'(cfg_r.table_base_id);
      REG_FRAME_SEL_MASK: prdata = 32'(cfg_r.frame_select_mask);
      REG_RESPONSE_ID:    prdata = 32'(cfg_r.response_id);
      REG_LIVE_DURATION:  prdata = 32'(cfg_r.live_duration_ms);
      REG_STALE_LIMIT:    prdata = 32'(cfg_r.stale_limit_ms);
      default:            prdata = '0;
    endcase
  end

endmodule

/* design/caf_match.sv */
module caf_match import caf_pkg::*; (
  input  caf_cfg_t   cfg,
  input  caf_in_t    item,
  input  logic       live_on,
  output caf_match_t res
);

  logic [ID_W:0]     id_x;
  logic [ID_W:0]     range_top;
  logic [ID_W:0]     quiet_top;
  logic [ID_W-1:0]   off;
  logic [TBIT_W-1:0] tbit;
  logic              hit;
  logic              acc_tab;

  assign id_x      = {1'b0, item.frame_id};
  assign range_top = {1'b0, cfg.range_base_id} + RANGE_SPAN;
  assign quiet_top = {1'b0, cfg.table_base_id} + QUIET_SPAN;
  assign off       = item.frame_id - cfg.table_base_id;
  assign tbit      = offset_to_bit(off);
  assign hit       = (tbit != NO_TABLE_BIT);
  assign acc_tab   = hit && (live_on || cfg.frame_select_mask[tbit]);

  // protocol decision for a received frame
  always_comb begin
    res.acc   = 1'b0;
    res.quiet = 1'b0;
    res.tbit  = NO_TABLE_BIT;
    if (item.cmd == CMD_FRAME) begin
      case (cfg.protocol_mode)
        MODE_RANGE: begin
          res.acc = (item.frame_id >= cfg.range_base_id) && (id_x <= range_top);
        end
        MODE_TABLE: begin
          if (item.frame_id >= cfg.table_base_id) begin
            res.tbit  = tbit;
            res.acc   = acc_tab;
            res.quiet = !acc_tab && (id_x < quiet_top);
          end
        end
        MODE_DIAG: begin
          res.acc = (item.frame_id == cfg.response_id) &&
                    (item.frame_len >= DIAG_MIN_LEN) &&
                    (item.second_byte == DIAG_MARK);
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/caf_engine.sv */
module caf_engine import caf_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  caf_cfg_t     cfg,
  caf_in_if.sink       in_chan,
  caf_out_if.source    out_chan
);

  logic                     s1_valid_r;
  caf_in_t                  s1_item_r;
  logic                     out_valid_r;
  caf_out_t                 out_data_r;
  caf_out_t                 out_data_nxt;
  logic                     advance;

  logic [MS_W-1:0]          live_r, live_nxt;
  logic [MS_W-1:0]          age_r, age_nxt;
  logic                     fresh_r, fresh_nxt;
  logic [COUNTER_WIDTH-1:0] seen_r, seen_nxt;
  logic [COUNTER_WIDTH-1:0] taken_r, taken_nxt;
  logic [63:0]              seen_ext, taken_ext;
  caf_match_t               m;

  caf_match u_match (
    .cfg     (cfg),
    .item    (s1_item_r),
    .live_on (live_r != '0),
    .res     (m)
  );

  // stage moves when the result register is free or being emptied
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // state update for the item in the stage
  always_comb begin
    live_nxt  = live_r;
    age_nxt   = age_r;
    fresh_nxt = fresh_r;
    seen_nxt  = seen_r;
    taken_nxt = taken_r;
    case (s1_item_r.cmd)
      CMD_FRAME: begin
        seen_nxt = seen_r + COUNTER_WIDTH'(1);
        if (m.acc) begin
          taken_nxt = taken_r + COUNTER_WIDTH'(1);
          age_nxt   = '0;
          fresh_nxt = 1'b1;
        end
      end
      CMD_TICK: begin
        if (live_r != '0) begin
          live_nxt = live_r - MS_W'(1);
        end
        if (age_r != AGE_MAX) begin
          age_nxt = age_r + MS_W'(1);
        end
        fresh_nxt = fresh_r && !(age_nxt > cfg.stale_limit_ms);
      end
      CMD_LIVE: begin
        live_nxt = cfg.live_duration_ms;
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    seen_ext                   = 64'(seen_nxt);
    taken_ext                  = 64'(taken_nxt);
    out_data_nxt.accepted      = m.acc;
    out_data_nxt.quiet_reject  = m.quiet;
    out_data_nxt.table_bit     = m.tbit;
    out_data_nxt.live_active   = (live_nxt != '0);
    out_data_nxt.data_valid    = fresh_nxt;
    out_data_nxt.total_count   = seen_ext[CNT_W-1:0];
    out_data_nxt.matched_count = taken_ext[CNT_W-1:0];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      age_r       <= '0;
      fresh_r     <= 1'b0;
      seen_r      <= '0;
      taken_r     <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        live_r      <= live_nxt;
        age_r       <= age_nxt;
        fresh_r     <= fresh_nxt;
        seen_r      <= seen_nxt;
        taken_r     <= taken_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r <= in_chan.data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* design/can_ecu_frame_acceptance_filter_core.sv */
// channel    | direction | handshake       | payload
// in_chan    | in        | valid / ready   | cmd, frame_id, frame_len, second_byte
// out_chan   | out       | valid / ready   | accepted .. matched_count
// apb        | in        | psel / penable  | paddr, pwdata, prdata, pready
//
// one item per cycle sustained while the result is taken; an input transaction reaches the result
// through the input register, then filter and state update into the result register
// rst_n is synchronous, active low; clears counters, live countdown and data age
// a stalled result holds the stage; the input register still takes an item
// while the stage is empty or moving on
module can_ecu_frame_acceptance_filter_core import caf_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  caf_in_if.sink      in_chan,
  caf_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  caf_cfg_t cfg;

  // configuration registers
  caf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // filter pipeline and state
  caf_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

/* design/caf_checker.sv */
module caf_checker import caf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input caf_out_t out_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an input transaction reaches the output through the input and result registers when the sink keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after input transaction");

  // an accepted frame refreshes the data and is never a quiet reject
  a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.data_valid && !out_data.quiet_reject)
    else $error("accepted frame with stale data or quiet reject");

endmodule

bind can_ecu_frame_acceptance_filter_core caf_checker u_caf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
